@@ rtl/core/uvts_pkg.sv @@
// ============================================================================
// uvts_pkg - shared types and constants of the UUID v1 text scanner
// Byte classes, per-offset expectations and position counter sizing.
// ============================================================================
package uvts_pkg;

    // Window and pattern geometry
    localparam int unsigned WIN_LEN    = 35;
    localparam int unsigned PAT_LEN    = WIN_LEN + 1;
    localparam int unsigned DASH_OFS_A = 8;
    localparam int unsigned DASH_OFS_B = 13;
    localparam int unsigned DASH_OFS_C = 18;
    localparam int unsigned DASH_OFS_D = 23;
    localparam int unsigned ONE_OFS    = 14;

    // Position counter saturates here; its width follows from it
    localparam longint unsigned MAX_OFFSET = 64'd65535;
    localparam int unsigned     POS_W      = $clog2(MAX_OFFSET + 64'd1);
    localparam int unsigned     OFS_W      = 16;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Two-bit class of one byte
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_HEX   = 2'd1,
        CLS_DASH  = 2'd2,
        CLS_ONE   = 2'd3
    } t_cls;

    // What a pattern offset requires
    typedef enum logic [1:0] {
        EXP_HEX  = 2'd0,
        EXP_DASH = 2'd1,
        EXP_ONE  = 2'd2
    } t_exp;

    // Reduce one byte to its class
    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if (b == CH_ONE) begin
            c = CLS_ONE;
        end else if (b inside {[CH_ZERO:CH_NINE], [CH_LOW_A:CH_LOW_F]}) begin
            c = CLS_HEX;
        end else if (b == CH_DASH) begin
            c = CLS_DASH;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

    // Requirement at a pattern offset, oldest byte at offset 0
    function automatic t_exp expect_at(input int unsigned k);
        t_exp e;
        if (k == DASH_OFS_A || k == DASH_OFS_B || k == DASH_OFS_C || k == DASH_OFS_D) begin
            e = EXP_DASH;
        end else if (k == ONE_OFS) begin
            e = EXP_ONE;
        end else begin
            e = EXP_HEX;
        end
        return e;
    endfunction

    // Check a class against a requirement
    function automatic logic class_ok(input t_cls c, input t_exp e);
        logic ok;
        case (e)
            EXP_DASH: ok = (c == CLS_DASH);
            EXP_ONE:  ok = (c == CLS_ONE);
            EXP_HEX:  ok = (c == CLS_HEX) || (c == CLS_ONE);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ rtl/core/uvts_in_if.sv @@
// ============================================================================
// uvts_in_if - byte channel into the scanner
// Valid/ready handshake carrying one text byte and its end-of-string flag.
// ============================================================================
interface uvts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

@@ rtl/core/uvts_out_if.sv @@
// ============================================================================
// uvts_out_if - result channel out of the scanner
// Valid/ready handshake carrying the found flag and the start offset.
// ============================================================================
interface uvts_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] start_offset;

    modport source (output valid, output found, output start_offset, input ready);
    modport sink   (input valid, input found, input start_offset, output ready);
endinterface

@@ rtl/core/uvts_cell.sv @@
// ============================================================================
// uvts_cell - one slot of the class window
// Holds the class of one past byte, passes it to the older neighbor on each
// shift and reports whether it meets the requirement of its pattern offset.
// ============================================================================
module uvts_cell
    import uvts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_clear,
    input  t_cls i_cls,
    input  t_exp i_exp,
    output t_cls o_cls,
    output logic o_ok
);

    t_cls r_cls;

    // Load from the newer neighbor; clear at end of string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cls <= CLS_OTHER;
        end else if (i_shift) begin
            r_cls <= i_cls;
        end
    end

    assign o_cls = r_cls;
    assign o_ok  = class_ok(r_cls, i_exp);

endmodule

@@ rtl/core/uuid_v1_text_scanner_top.sv @@
// ============================================================================
// uuid_v1_text_scanner_top - streaming finder of version-1 UUID text
// Shifts byte classes through a row of cells and checks all 36 offsets of
// the 8-4-4-4-12 layout in parallel; reports the first match or end of string.
// ============================================================================
//
//  channel | dir | payload                    | note
//  --------+-----+----------------------------+------------------------------
//  i_in    | in  | char_byte[7:0], last_byte  | one text byte per item
//  o_out   | out | found, start_offset[15:0]  | at most one item per string
//
//  One byte is taken per cycle; a result goes into the output register, or
//  into the skid register while the output register holds one. The window
//  check over the cell row is combinational, so the row sets the rate.
//  A skid register behind the output register keeps input flowing while a
//  result waits; input stalls only when both hold a result.
//  Reset clears the window to class other, the position and the found latch.
//
module uuid_v1_text_scanner_top
    import uvts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    uvts_in_if.sink    i_in,
    uvts_out_if.source o_out
);

    logic                     accept;
    logic                     shift;
    logic                     clear;
    t_cls                     cls_chain [PAT_LEN];
    logic [PAT_LEN-1:0]       ok_vec;
    logic                     match;
    logic                     new_v;
    logic [OFS_W-1:0]         new_ofs;
    logic [POS_W-1:0]         start_pos;

    logic                     r_latched;
    logic                     n_latched;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;

    logic                     r_out_v;
    logic                     r_out_found;
    logic [OFS_W-1:0]         r_out_ofs;
    logic                     r_skid_v;
    logic                     r_skid_found;
    logic [OFS_W-1:0]         r_skid_ofs;

    // Input handshake
    assign i_in.ready = !r_skid_v;
    assign accept     = i_in.valid && i_in.ready;
    assign shift      = accept && !r_latched;
    assign clear      = accept && i_in.last_byte;

    // Newest class enters at the top of the chain
    assign cls_chain[WIN_LEN] = classify(i_in.char_byte);
    assign ok_vec[WIN_LEN]    = class_ok(cls_chain[WIN_LEN], expect_at(WIN_LEN));

    // Row of window cells, oldest at index 0
    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        uvts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_cls   (cls_chain[k+1]),
            .i_exp   (expect_at(k)),
            .o_cls   (cls_chain[k]),
            .o_ok    (ok_vec[k])
        );
    end

    assign match = &ok_vec;

    // Start offset of the run that ends with this byte
    assign start_pos = (r_pos >= POS_W'(WIN_LEN)) ? (r_pos - POS_W'(WIN_LEN)) : '0;
    assign new_ofs   = match ? OFS_W'(start_pos) : '0;
    assign new_v     = accept && !r_latched && (match || i_in.last_byte);

    // Next position and found latch
    always_comb begin
        n_pos     = r_pos;
        n_latched = r_latched;
        if (clear) begin
            n_pos     = '0;
            n_latched = 1'b0;
        end else if (shift) begin
            if (64'(r_pos) < MAX_OFFSET) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (match) begin
                n_latched = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_latched <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_latched <= n_latched;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= new_v;
            end else begin
                r_out_v  <= new_v;
            end
        end else if (new_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_found  <= r_skid_found;
                r_out_ofs    <= r_skid_ofs;
                r_skid_found <= match;
                r_skid_ofs   <= new_ofs;
            end else begin
                r_out_found  <= match;
                r_out_ofs    <= new_ofs;
            end
        end else if (new_v) begin
            r_skid_found <= match;
            r_skid_ofs   <= new_ofs;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.found        = r_out_found;
    assign o_out.start_offset = r_out_ofs;

endmodule

@@ tb/uvts_scan_checker.sv @@
// ============================================================================
// uvts_scan_checker - result predictor and scoreboard for the UUID v1 scanner
// Watches both channels, tracks the byte-class window, position and found
// latch per accepted item, and checks each result item against the oldest
// prediction.
// ============================================================================
module uvts_scan_checker
    import uvts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    uvts_in_if   i_in_mon,
    uvts_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] start_offset;
    } t_scan_result;

    // Predicted scanner state
    t_cls             class_win [WIN_LEN];
    logic [POS_W-1:0] next_pos;
    logic             uuid_seen;

    t_scan_result scan_results_q [$];
    t_scan_result head;
    int           fail_total = 0;

    // Class of one text byte
    function automatic t_cls byte_class(input logic [7:0] b);
        if (b == CH_ONE) begin
            return CLS_ONE;
        end
        if ((b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOW_A && b <= CH_LOW_F)) begin
            return CLS_HEX;
        end
        if (b == CH_DASH) begin
            return CLS_DASH;
        end
        return CLS_OTHER;
    endfunction

    // Clear the scan, as after reset or after a final byte
    task automatic clear_scan();
        for (int k = 0; k < WIN_LEN; k++) begin
            class_win[k] = CLS_OTHER;
        end
        next_pos  = '0;
        uuid_seen = 1'b0;
    endtask

    // Advance the scan by one byte and queue the result it causes, if any
    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        t_cls         seq [PAT_LEN];
        bit           fits;
        t_scan_result r;
        if (!uuid_seen) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                seq[k] = class_win[k];
            end
            seq[WIN_LEN] = byte_class(b);

            // Match the 8-4-4-4-12 layout, oldest byte at offset 0
            fits = 1'b1;
            for (int k = 0; k < PAT_LEN; k++) begin
                if (k == DASH_OFS_A || k == DASH_OFS_B || k == DASH_OFS_C
                        || k == DASH_OFS_D) begin
                    fits = fits && (seq[k] == CLS_DASH);
                end else if (k == ONE_OFS) begin
                    fits = fits && (seq[k] == CLS_ONE);
                end else begin
                    fits = fits && (seq[k] == CLS_HEX || seq[k] == CLS_ONE);
                end
            end

            if (fits) begin
                uuid_seen      = 1'b1;
                r.found        = 1'b1;
                r.start_offset = (next_pos >= WIN_LEN) ? OFS_W'(next_pos - WIN_LEN) : '0;
                scan_results_q.push_back(r);
            end else if (is_last) begin
                r.found        = 1'b0;
                r.start_offset = '0;
                scan_results_q.push_back(r);
            end

            // Shift the window and advance the saturating position
            for (int k = 0; k < WIN_LEN; k++) begin
                class_win[k] = seq[k + 1];
            end
            if (next_pos < MAX_OFFSET) begin
                next_pos = next_pos + 1'b1;
            end
        end
        if (is_last) begin
            clear_scan();
        end
    endtask

    // Compare results first: a result at this edge stems from an older item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            scan_results_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (scan_results_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual found=%0d ofs=%0d",
                             $time, i_out_mon.found, i_out_mon.start_offset);
                    fail_total++;
                end else begin
                    head = scan_results_q.pop_front();
                    if (i_out_mon.found !== head.found) begin
                        $display("%0t: found differs, expected %0d actual %0d",
                                 $time, head.found, i_out_mon.found);
                        fail_total++;
                    end
                    if (i_out_mon.start_offset !== head.start_offset) begin
                        $display("%0t: start_offset differs, expected %0d actual %0d",
                                 $time, head.start_offset, i_out_mon.start_offset);
                        fail_total++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                scan_byte(i_in_mon.char_byte, i_in_mon.last_byte);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= scan_results_q.size();
    end

endmodule

@@ tb/uuid_v1_text_scanner_top_tb.sv @@
// ============================================================================
// uuid_v1_text_scanner_top_tb - stimulus and verdict for the UUID v1 scanner
// Sends short directed strings, then random strings that are mostly valid
// v1 UUIDs in noise, near misses and overlaps, under three idling mixes
// and a long receiver hold-off.
// ============================================================================
module uuid_v1_text_scanner_top_tb
    import uvts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 440;
    localparam int TAIL_CYCLES = 6;

    // Neighbors of the hex and dash ranges, and uppercase hex
    localparam logic [7:0] NEAR_MISS [8] = '{8'h2F, 8'h3A, 8'h60, 8'h67,
                                             8'h41, 8'h46, 8'h2C, 8'h2E};

    logic i_clk = 1'b0;
    logic i_rst_n;

    uvts_in_if  in_ch ();
    uvts_out_if out_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_start    = 1'b0;

    logic [7:0] text_q [$];

    uuid_v1_text_scanner_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    uvts_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uuid_v1_text_scanner_top: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_start) begin
                hold_start = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    out_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge i_clk);
        end
    end

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        return (v < 10) ? CH_ZERO + 8'(v) : CH_LOW_A + 8'(v - 10);
    endfunction

    // Mix of arbitrary bytes and characters the scanner cares about
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 255));
            1:       return hex_char();
            2:       return CH_DASH;
            3:       return CH_ONE;
            default: return NEAR_MISS[$urandom_range(0, 7)];
        endcase
    endfunction

    // Character that breaks the layout at offset k
    function automatic logic [7:0] wrong_char(input int k);
        if (k == DASH_OFS_A || k == DASH_OFS_B || k == DASH_OFS_C || k == DASH_OFS_D) begin
            return $urandom_range(0, 1) ? hex_char() : NEAR_MISS[$urandom_range(0, 7)];
        end
        if (k == ONE_OFS) begin
            case ($urandom_range(0, 3))
                0:       return CH_ZERO;
                1:       return CH_LOW_F;
                2:       return CH_DASH;
                default: return NEAR_MISS[$urandom_range(0, 7)];
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return CH_DASH;
            1:       return 8'h00;
            default: return NEAR_MISS[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) begin
            text_q.push_back(noise_char());
        end
    endtask

    // Append the first count bytes of a fresh v1 UUID
    task automatic push_uuid(input int count);
        for (int k = 0; k < count; k++) begin
            if (k == DASH_OFS_A || k == DASH_OFS_B || k == DASH_OFS_C || k == DASH_OFS_D) begin
                text_q.push_back(CH_DASH);
            end else if (k == ONE_OFS) begin
                text_q.push_back(CH_ONE);
            end else begin
                text_q.push_back(hex_char());
            end
        end
    endtask

    task automatic push_broken_uuid();
        int k;
        push_uuid(PAT_LEN);
        k = $urandom_range(0, PAT_LEN - 1);
        text_q[text_q.size() - PAT_LEN + k] = wrong_char(k);
    endtask

    // Offer one item, idling first at the sender's rate
    task automatic send_item(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= b;
        in_ch.last_byte <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Send the built string, flag its final byte, and clear it
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_item(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_string();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // valid UUID after noise or a partial UUID, with a tail ignored
                if ($urandom_range(0, 1)) begin
                    push_noise($urandom_range(0, 6));
                end else begin
                    push_uuid($urandom_range(1, PAT_LEN - 1));
                end
                push_uuid(PAT_LEN);
                push_noise($urandom_range(0, 4));
            end
            5, 6: begin
                push_broken_uuid();
                push_noise($urandom_range(0, 3));
            end
            7: begin
                // near miss, then a good one
                push_broken_uuid();
                push_uuid(PAT_LEN);
            end
            default: begin
                push_noise($urandom_range(1, 12));
            end
        endcase
        send_text();
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            random_string();
        end
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.char_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes as one-byte strings, then the boundary chars
        send_idle_pct = 0;
        recv_idle_pct = 0;
        text_q.push_back(8'h00);
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        text_q.push_back(CH_ONE);
        send_text();
        text_q.push_back(CH_DASH);
        send_text();
        // zero byte inside a string does not end it
        text_q.push_back(CH_ONE);
        text_q.push_back(CH_DASH);
        text_q.push_back(8'h00);
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_NINE);
        text_q.push_back(CH_LOW_A);
        text_q.push_back(CH_LOW_F);
        for (int i = 0; i < 8; i++) begin
            text_q.push_back(NEAR_MISS[i]);
        end
        send_text();
        drain();

        run_phase(19, 86, PHASE_ITEMS);
        run_phase(86, 19, PHASE_ITEMS);

        // Hold the receiver while one-byte strings keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start    = 1'b1;
        for (int i = 0; i < 40; i++) begin
            text_q.push_back(noise_char());
            send_text();
        end
        run_phase(0, 0, PHASE_ITEMS);

        if (fail_count == 0 && pending == 0) begin
            $display("uuid_v1_text_scanner_top: match");
        end else begin
            $display("uuid_v1_text_scanner_top: mismatch");
        end
        $finish;
    end

endmodule
